// ----- rtl/btpl_pkg.sv -----
// ============================================================================
// btpl_pkg
// Shared types and constants of the button trace parser and lookup block.
// ============================================================================
package btpl_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int TOKEN_MAX_DEF   = 31;
    localparam int HELD_W          = 13;
    localparam logic [31:0] MASK_LIMIT = 32'h0000_ffff;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_BYTE   = 2'd1,
        OP_END    = 2'd2,
        OP_LOOKUP = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        PH_TOP, PH_COMMENT, PH_PRE_KEY, PH_KEY, PH_POST_KEY, PH_PRE_VAL,
        PH_V_LEAD, PH_V_SIGNED, PH_V_ZERO, PH_V_HEXPFX, PH_V_DIGITS,
        PH_V_BAD, PH_POST_VAL
    } t_phase;

    typedef enum logic [1:0] {
        KEY_NONE, KEY_FRAME, KEY_BUTTONS, KEY_BAD
    } t_key;

    typedef enum logic [1:0] {
        RX_DEC, RX_OCT, RX_HEX
    } t_radix;

    typedef enum logic [1:0] {
        LK_IDLE, LK_READ, LK_CMP
    } t_lk_state;

    typedef enum logic {
        RK_STATUS = 1'b0,
        RK_LOOKUP = 1'b1
    } t_kind;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [15:0] mask;
    } t_lk_stat;

endpackage

// ----- rtl/btpl_if.sv -----
// ============================================================================
// btpl_in_if / btpl_out_if
// Valid/ready channels for requests into and results out of the block.
// ============================================================================
interface btpl_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [7:0]  data_byte;
    logic [31:0] query_frame;

    modport source (output valid, output operation, output data_byte,
                    output query_frame, input ready);
    modport sink   (input valid, input operation, input data_byte,
                    input query_frame, output ready);
endinterface

interface btpl_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic        parse_ok;
    logic [15:0] buttons_mask;
    logic [12:0] entries_held;

    modport source (output valid, output result_kind, output parse_ok,
                    output buttons_mask, output entries_held, input ready);
    modport sink   (input valid, input result_kind, input parse_ok,
                    input buttons_mask, input entries_held, output ready);
endinterface

// ----- rtl/btpl_table.sv -----
// ============================================================================
// btpl_table
// Entry memory with a binary search that returns the mask of the last entry
// whose frame is at or below the query.
// ============================================================================
module btpl_table #(
    parameter int TABLE_DEPTH = btpl_pkg::TABLE_DEPTH_DEF,
    localparam int CW = $clog2(TABLE_DEPTH + 1),
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_en,
    input  logic [AW-1:0]      i_wr_addr,
    input  logic [31:0]        i_wr_frame,
    input  logic [15:0]        i_wr_mask,
    input  logic               i_lk_start,
    input  logic [31:0]        i_query,
    input  logic [CW-1:0]      i_total,
    output btpl_pkg::t_lk_stat o_stat
);
    import btpl_pkg::*;

    logic [47:0] r_mem [TABLE_DEPTH];
    logic [47:0] r_rd_data;

    t_lk_state   r_state, n_state;
    logic [CW-1:0] r_lo, n_lo, r_hi, n_hi, r_mid, n_mid;
    logic [31:0] r_query, n_query;
    logic [15:0] r_best, n_best;
    logic [CW:0] mid_sum;
    logic        rd_en;

    assign mid_sum = ({1'b0, r_lo} + {1'b0, r_hi}) >> 1;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_frame, i_wr_mask};
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[mid_sum[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LK_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_query <= n_query;
        r_best  <= n_best;
    end

    always_comb begin
        n_state = r_state;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_mid   = r_mid;
        n_query = r_query;
        n_best  = r_best;
        rd_en   = 1'b0;
        o_stat.busy = (r_state != LK_IDLE);
        o_stat.done = 1'b0;
        o_stat.mask = r_best;
        case (r_state)
            LK_IDLE: begin
                if (i_lk_start) begin
                    n_lo    = '0;
                    n_hi    = i_total;
                    n_query = i_query;
                    n_best  = '0;
                    n_state = LK_READ;
                end
            end
            LK_READ: begin
                if (r_lo < r_hi) begin
                    rd_en   = 1'b1;
                    n_mid   = mid_sum[CW-1:0];
                    n_state = LK_CMP;
                end else begin
                    o_stat.done = 1'b1;
                    n_state     = LK_IDLE;
                end
            end
            LK_CMP: begin
                // The last entry at or below the query sets the answer.
                if (r_rd_data[47:16] <= r_query) begin
                    n_lo   = r_mid + CW'(1);
                    n_best = r_rd_data[15:0];
                end else begin
                    n_hi = r_mid;
                end
                n_state = LK_READ;
            end
            default: begin
                n_state = LK_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/button_trace_parse_and_lookup.sv -----
// ============================================================================
// button_trace_parse_and_lookup
// Parses {"frame":N,"buttons":M} text into a frame/mask table and answers
// lookups against it.
// ============================================================================
// A start request clears the table and the sticky error. Byte requests feed
// the trace text one character per cycle when not stalled; each closing brace
// of a good record writes one entry into the table memory in that same cycle.
// An end request returns the parse status on the next cycle. A lookup walks
// the table as a binary search over the single read port of the memory: each
// halving step reads the middle entry and then compares it with the query,
// and the answer goes to the output register once the range is empty. While
// a lookup runs or a result waits at the output, further requests stall until
// the result is taken.
module button_trace_parse_and_lookup #(
    parameter int TABLE_DEPTH     = btpl_pkg::TABLE_DEPTH_DEF,
    parameter int TOKEN_MAX_CHARS = btpl_pkg::TOKEN_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    btpl_in_if.sink           i_req,
    btpl_out_if.source        o_rsp
);
    import btpl_pkg::*;

    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int TL_W = $clog2(TOKEN_MAX_CHARS + 1);

    // Parser state
    t_phase        r_phase, n_phase;
    logic [2:0]    r_kpos, n_kpos;
    t_key          r_key, n_key;
    logic [63:0]   r_acc, n_acc;
    logic          r_neg, n_neg;
    logic          r_ovf, n_ovf;
    t_radix        r_radix, n_radix;
    logic [TL_W-1:0] r_len, n_len;
    logic          r_quoted, n_quoted;
    logic [31:0]   r_pframe, n_pframe;
    logic [31:0]   r_pmask, n_pmask;
    logic [1:0]    r_seen, n_seen;
    logic [31:0]   r_prev, n_prev;
    logic          r_prev_valid, n_prev_valid;
    logic          r_failed, n_failed;
    logic [CW-1:0] r_total, n_total;

    // Output register
    logic          r_out_valid;
    t_kind         r_out_kind;
    logic          r_out_ok;
    logic [15:0]   r_out_mask;
    logic [12:0]   r_out_held;

    logic          acc_in, fail, wr_en, lk_start, load_status;
    logic          do_val, do_post, do_finish;
    t_phase        v_phase;
    logic [TL_W-1:0] v_len;
    logic          v_quoted;
    logic [7:0]    ch;
    logic [4:0]    dig;
    logic [67:0]   prod;
    logic [31:0]   val32;
    logic          is_term, is_sptab;
    logic [CW+HELD_W-1:0] held_ext;
    t_lk_stat      lk;

    function automatic logic [7:0] frame_ch(input logic [2:0] p);
        case (p)
            3'd0: frame_ch = "f";
            3'd1: frame_ch = "r";
            3'd2: frame_ch = "a";
            3'd3: frame_ch = "m";
            3'd4: frame_ch = "e";
            default: frame_ch = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] buttons_ch(input logic [2:0] p);
        case (p)
            3'd0: buttons_ch = "b";
            3'd1: buttons_ch = "u";
            3'd2: buttons_ch = "t";
            3'd3: buttons_ch = "t";
            3'd4: buttons_ch = "o";
            3'd5: buttons_ch = "n";
            3'd6: buttons_ch = "s";
            default: buttons_ch = 8'h00;
        endcase
    endfunction

    function automatic logic [4:0] digit_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            digit_of = 5'(c - "0");
        end else if (c >= "a" && c <= "f") begin
            digit_of = 5'(c - "a" + 8'd10);
        end else if (c >= "A" && c <= "F") begin
            digit_of = 5'(c - "A" + 8'd10);
        end else begin
            digit_of = 5'd16;
        end
    endfunction

    assign ch       = i_req.data_byte;
    assign dig      = digit_of(ch);
    assign is_sptab = (ch == " ") || (ch == 8'h09);
    assign is_term  = (ch == ",") || (ch == "}") || (ch == "\"") || is_sptab ||
                      (ch == 8'h0d) || (ch == 8'h0a);

    // Accumulate step: shift-and-add by the radix, carry out of bit 63 means
    // the magnitude saturates.
    always_comb begin
        case (r_radix)
            RX_OCT:  prod = {4'b0, r_acc} << 3;
            RX_HEX:  prod = {4'b0, r_acc} << 4;
            default: prod = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1);
        endcase
        prod = prod + 68'(dig[3:0]);
    end

    // Value of a finished token, low 32 bits after sign and saturation.
    assign val32 = r_ovf ? 32'hffff_ffff : (r_neg ? (32'd0 - r_acc[31:0]) : r_acc[31:0]);

    // Hold requests while a lookup runs or a result waits.
    assign i_req.ready = !lk.busy && (!r_out_valid || o_rsp.ready);
    assign acc_in      = i_req.valid && i_req.ready;

    always_comb begin
        n_phase = r_phase;   n_kpos = r_kpos;     n_key = r_key;
        n_acc = r_acc;       n_neg = r_neg;       n_ovf = r_ovf;
        n_radix = r_radix;   n_len = r_len;       n_quoted = r_quoted;
        n_pframe = r_pframe; n_pmask = r_pmask;   n_seen = r_seen;
        n_prev = r_prev;     n_prev_valid = r_prev_valid;
        n_total = r_total;
        fail = 1'b0;  wr_en = 1'b0;  lk_start = 1'b0;  load_status = 1'b0;
        do_val = 1'b0;  do_post = 1'b0;  do_finish = 1'b0;
        v_phase = r_phase;  v_len = r_len;  v_quoted = r_quoted;

        if (acc_in && t_op'(i_req.operation) == OP_BYTE && !r_failed) begin
            case (r_phase)
                PH_TOP: begin
                    if (ch == "#") begin
                        n_phase = PH_COMMENT;
                    end else if (ch == "{") begin
                        n_phase = PH_PRE_KEY;
                        n_seen = '0;  n_pframe = '0;  n_pmask = '0;
                    end else if (!(is_sptab || ch == 8'h0d || ch == 8'h0a)) begin
                        fail = 1'b1;
                    end
                end
                PH_COMMENT: begin
                    if (ch == 8'h0a) n_phase = PH_TOP;
                end
                PH_PRE_KEY: begin
                    if (ch == "\"") begin
                        n_phase = PH_KEY;  n_key = KEY_NONE;  n_kpos = '0;
                    end else if (!is_sptab) begin
                        fail = 1'b1;
                    end
                end
                PH_KEY: begin
                    if (ch == "\"") begin
                        if ((r_key == KEY_FRAME && r_kpos == 3'd5) ||
                            (r_key == KEY_BUTTONS && r_kpos == 3'd7)) begin
                            n_phase = PH_POST_KEY;
                        end else begin
                            fail = 1'b1;
                        end
                    end else begin
                        case (r_key)
                            KEY_NONE: begin
                                if (ch == "f") begin
                                    n_key = KEY_FRAME;  n_kpos = 3'd1;
                                end else if (ch == "b") begin
                                    n_key = KEY_BUTTONS;  n_kpos = 3'd1;
                                end else begin
                                    n_key = KEY_BAD;
                                end
                            end
                            KEY_FRAME: begin
                                if (r_kpos < 3'd5 && ch == frame_ch(r_kpos)) n_kpos = r_kpos + 3'd1;
                                else n_key = KEY_BAD;
                            end
                            KEY_BUTTONS: begin
                                if (r_kpos < 3'd7 && ch == buttons_ch(r_kpos)) n_kpos = r_kpos + 3'd1;
                                else n_key = KEY_BAD;
                            end
                            default: begin
                                n_key = KEY_BAD;
                            end
                        endcase
                    end
                end
                PH_POST_KEY: begin
                    if (ch == ":") n_phase = PH_PRE_VAL;
                    else if (!is_sptab) fail = 1'b1;
                end
                PH_PRE_VAL: begin
                    if (!is_sptab) begin
                        // Open a new token; an opening quote is consumed here.
                        n_quoted = (ch == "\"");
                        n_acc = '0;  n_neg = 1'b0;  n_ovf = 1'b0;
                        n_radix = RX_DEC;  n_len = '0;  n_phase = PH_V_LEAD;
                        v_phase = PH_V_LEAD;  v_len = '0;  v_quoted = 1'b0;
                        do_val = (ch != "\"");
                    end
                end
                PH_V_LEAD, PH_V_SIGNED, PH_V_ZERO, PH_V_HEXPFX,
                PH_V_DIGITS, PH_V_BAD: begin
                    do_val = 1'b1;
                end
                PH_POST_VAL: begin
                    do_post = 1'b1;
                end
                default: begin
                    fail = 1'b1;
                end
            endcase
        end

        if (do_val) begin
            if (is_term) begin
                if (v_len == '0 || !(v_phase == PH_V_ZERO || v_phase == PH_V_DIGITS)) begin
                    fail = 1'b1;
                end else begin
                    if (r_key == KEY_FRAME) begin
                        n_pframe = val32;  n_seen = n_seen | 2'b01;
                    end else begin
                        n_pmask = val32;   n_seen = n_seen | 2'b10;
                    end
                    n_phase = PH_POST_VAL;
                    if (v_quoted) begin
                        if (ch != "\"") fail = 1'b1;
                    end else begin
                        do_post = 1'b1;
                    end
                end
            end else if (v_len >= TL_W'(TOKEN_MAX_CHARS)) begin
                fail = 1'b1;
            end else begin
                n_len = v_len + TL_W'(1);
                case (v_phase)
                    PH_V_LEAD, PH_V_SIGNED: begin
                        if (v_phase == PH_V_LEAD && (ch == 8'h0b || ch == 8'h0c)) begin
                            n_phase = v_phase;
                        end else if (v_phase == PH_V_LEAD && (ch == "+" || ch == "-")) begin
                            n_neg = (ch == "-");  n_phase = PH_V_SIGNED;
                        end else if (ch == "0") begin
                            n_phase = PH_V_ZERO;
                        end else if (ch >= "1" && ch <= "9") begin
                            n_radix = RX_DEC;  n_acc = 64'(dig);  n_phase = PH_V_DIGITS;
                        end else begin
                            n_phase = PH_V_BAD;
                        end
                    end
                    PH_V_ZERO: begin
                        if (ch == "x" || ch == "X") begin
                            n_phase = PH_V_HEXPFX;
                        end else if (ch >= "0" && ch <= "7") begin
                            n_radix = RX_OCT;  n_acc = 64'(dig);  n_phase = PH_V_DIGITS;
                        end else begin
                            n_phase = PH_V_BAD;
                        end
                    end
                    PH_V_HEXPFX: begin
                        if (dig < 5'd16) begin
                            n_radix = RX_HEX;  n_acc = 64'(dig);  n_phase = PH_V_DIGITS;
                        end else begin
                            n_phase = PH_V_BAD;
                        end
                    end
                    PH_V_DIGITS: begin
                        if ((r_radix == RX_DEC && dig < 5'd10) ||
                            (r_radix == RX_OCT && dig < 5'd8) ||
                            (r_radix == RX_HEX && dig < 5'd16)) begin
                            if (!r_ovf) begin
                                if (prod[67:64] != 4'd0) n_ovf = 1'b1;
                                else n_acc = prod[63:0];
                            end
                        end else begin
                            n_phase = PH_V_BAD;
                        end
                    end
                    default: begin
                        n_phase = PH_V_BAD;
                    end
                endcase
            end
        end

        if (do_post) begin
            if (ch == ",") n_phase = PH_PRE_KEY;
            else if (ch == "}") do_finish = 1'b1;
            else if (!is_sptab) fail = 1'b1;
        end

        // Close a record: both fields present, mask in range, frame rising,
        // and room left in the table.
        if (do_finish) begin
            if (n_seen != 2'b11 || n_pmask > MASK_LIMIT ||
                (r_prev_valid && n_pframe <= r_prev) ||
                r_total >= CW'(TABLE_DEPTH)) begin
                fail = 1'b1;
            end else begin
                wr_en = 1'b1;
                n_total = r_total + CW'(1);
                n_prev = n_pframe;
                n_prev_valid = 1'b1;
                n_phase = PH_TOP;
            end
        end

        n_failed = r_failed | fail;

        if (acc_in) begin
            case (t_op'(i_req.operation))
                OP_START: begin
                    n_phase = PH_TOP;  n_kpos = '0;  n_key = KEY_NONE;
                    n_acc = '0;  n_neg = 1'b0;  n_ovf = 1'b0;  n_radix = RX_DEC;
                    n_len = '0;  n_quoted = 1'b0;  n_pframe = '0;  n_pmask = '0;
                    n_seen = '0;  n_prev = '0;  n_prev_valid = 1'b0;
                    n_failed = 1'b0;  n_total = '0;
                end
                OP_END: begin
                    if (r_phase != PH_TOP && r_phase != PH_COMMENT) n_failed = 1'b1;
                    n_phase = PH_TOP;
                    load_status = 1'b1;
                end
                OP_LOOKUP: begin
                    lk_start = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TOP;  r_kpos <= '0;  r_key <= KEY_NONE;
            r_acc <= '0;  r_neg <= 1'b0;  r_ovf <= 1'b0;  r_radix <= RX_DEC;
            r_len <= '0;  r_quoted <= 1'b0;  r_pframe <= '0;  r_pmask <= '0;
            r_seen <= '0;  r_prev <= '0;  r_prev_valid <= 1'b0;
            r_failed <= 1'b0;  r_total <= '0;
        end else begin
            r_phase <= n_phase;  r_kpos <= n_kpos;  r_key <= n_key;
            r_acc <= n_acc;  r_neg <= n_neg;  r_ovf <= n_ovf;  r_radix <= n_radix;
            r_len <= n_len;  r_quoted <= n_quoted;  r_pframe <= n_pframe;
            r_pmask <= n_pmask;  r_seen <= n_seen;  r_prev <= n_prev;
            r_prev_valid <= n_prev_valid;  r_failed <= n_failed;  r_total <= n_total;
        end
    end

    btpl_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_en),
        .i_wr_addr  (r_total[AW-1:0]),
        .i_wr_frame (n_pframe),
        .i_wr_mask  (n_pmask[15:0]),
        .i_lk_start (lk_start),
        .i_query    (i_req.query_frame),
        .i_total    (r_total),
        .o_stat     (lk)
    );

    assign held_ext = {{HELD_W{1'b0}}, r_total};

    // Output register: load a status or a lookup answer, drop when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_status || lk.done) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
        if (load_status) begin
            r_out_kind <= RK_STATUS;
            r_out_ok   <= !n_failed;
            r_out_mask <= '0;
            r_out_held <= held_ext[HELD_W-1:0];
        end else if (lk.done) begin
            r_out_kind <= RK_LOOKUP;
            r_out_ok   <= 1'b0;
            r_out_mask <= lk.mask;
            r_out_held <= held_ext[HELD_W-1:0];
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.result_kind  = r_out_kind;
    assign o_rsp.parse_ok     = r_out_ok;
    assign o_rsp.buttons_mask = r_out_mask;
    assign o_rsp.entries_held = r_out_held;

endmodule

// ----- rtl/btpl_check.sv -----
// ============================================================================
// btpl_check
// Port-level checks of the button trace parser, bound to the top level.
// ============================================================================
module btpl_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_kind,
    input logic        i_out_ok,
    input logic [15:0] i_out_mask
);
    import btpl_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_stall_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("request taken while a result is stuck");

    a_status_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == RK_STATUS |-> i_out_mask == 16'd0)
        else $error("status result carries a mask");

    a_lookup_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == RK_LOOKUP |-> !i_out_ok)
        else $error("lookup result carries parse status");

endmodule

bind button_trace_parse_and_lookup btpl_check u_btpl_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_kind  (o_rsp.result_kind),
    .i_out_ok    (o_rsp.parse_ok),
    .i_out_mask  (o_rsp.buttons_mask)
);

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Button trace parser testbench
// Streams start, trace text, end-of-buffer and lookup requests into the
// block with random idling on both channels. A built-in predictor of the
// parser and the frame table computes each expected status or lookup answer,
// and the response monitor checks every field in order.
// ----------------------------------------------------------------------------
module testbench;
    import btpl_pkg::*;

    localparam int DEPTH   = TABLE_DEPTH_DEF;
    localparam int TOK_MAX = TOKEN_MAX_DEF;
    localparam logic [7:0] CH_TAB = 8'h09, CH_LF = 8'h0a, CH_VT = 8'h0b;
    localparam logic [7:0] CH_FF = 8'h0c, CH_CR = 8'h0d;

    typedef struct {
        t_op         op;
        logic [7:0]  data;
        logic [31:0] query;
        bit          drain;     // pause here until all results are back
    } request_t;

    typedef struct {
        t_kind       kind;
        logic        ok;
        logic [15:0] mask;
        logic [12:0] held;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    btpl_in_if  req_if();
    btpl_out_if rsp_if();

    button_trace_parse_and_lookup dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    always #4 clk = ~clk;

    request_t pending_reqs[$];
    answer_t  expected_answers[$];
    int       error_count = 0;
    int       accepted = 0;
    int       total_reqs = 0;
    bit       draining = 1'b0;

    // ---------------------------------------------------------------------
    // Parser and table predictor
    // ---------------------------------------------------------------------
    t_phase      phase;
    t_key        key_kind;
    int          key_pos;
    logic [63:0] acc;
    bit          neg, ovf, quoted, failed, prev_seen;
    int          radix, tok_len, entry_cnt;
    logic [31:0] frame_val, mask_val, prev_frame;
    logic [1:0]  seen;
    logic [31:0] tbl_frame [DEPTH];
    logic [15:0] tbl_mask  [DEPTH];

    task automatic clear_trace();
        phase = PH_TOP; key_kind = KEY_NONE; key_pos = 0; acc = '0;
        neg = 0; ovf = 0; quoted = 0; failed = 0; prev_seen = 0;
        radix = 10; tok_len = 0; entry_cnt = 0;
        frame_val = '0; mask_val = '0; prev_frame = '0; seen = '0;
    endtask

    function automatic int digit_of(logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return 16;
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == " " || c == CH_TAB;
    endfunction

    task automatic close_record();
        if (seen != 2'b11 || mask_val > MASK_LIMIT) begin
            failed = 1;
        end else if (prev_seen && frame_val <= prev_frame) begin
            failed = 1;
        end else if (entry_cnt >= DEPTH) begin
            failed = 1;
        end else begin
            tbl_frame[entry_cnt] = frame_val;
            tbl_mask[entry_cnt]  = mask_val[15:0];
            entry_cnt++;
            prev_frame = frame_val;
            prev_seen  = 1;
            phase      = PH_TOP;
        end
    endtask

    task automatic after_value(logic [7:0] c);
        if (is_blank(c)) return;
        if (c == ",") phase = PH_PRE_KEY;
        else if (c == "}") close_record();
        else failed = 1;
    endtask

    task automatic digit_step(logic [7:0] c);
        int d;
        logic [63:0] lim;
        d = digit_of(c);
        if (phase == PH_V_LEAD) begin
            if (c == CH_VT || c == CH_FF) return;
            if (c == "+" || c == "-") begin
                neg = (c == "-");
                phase = PH_V_SIGNED;
                return;
            end
        end
        case (phase)
            PH_V_LEAD, PH_V_SIGNED: begin
                if (c == "0") phase = PH_V_ZERO;
                else if (c >= "1" && c <= "9") begin
                    radix = 10; acc = 64'(d); phase = PH_V_DIGITS;
                end else phase = PH_V_BAD;
            end
            PH_V_ZERO: begin
                if (c == "x" || c == "X") phase = PH_V_HEXPFX;
                else if (c >= "0" && c <= "7") begin
                    radix = 8; acc = 64'(d); phase = PH_V_DIGITS;
                end else phase = PH_V_BAD;
            end
            PH_V_HEXPFX: begin
                if (d < 16) begin
                    radix = 16; acc = 64'(d); phase = PH_V_DIGITS;
                end else phase = PH_V_BAD;
            end
            PH_V_DIGITS: begin
                if (d >= radix) phase = PH_V_BAD;
                else if (!ovf) begin
                    lim = ({64{1'b1}} - 64'(d)) / 64'(radix);
                    if (acc > lim) ovf = 1;
                    else acc = acc * 64'(radix) + 64'(d);
                end
            end
            default: phase = PH_V_BAD;
        endcase
    endtask

    task automatic value_char(logic [7:0] c);
        logic [63:0] full;
        if (c == "," || c == "}" || c == "\"" || is_blank(c) || c == CH_CR || c == CH_LF) begin
            if (tok_len == 0 || (phase != PH_V_ZERO && phase != PH_V_DIGITS)) begin
                failed = 1;
                return;
            end
            if (phase == PH_V_ZERO) full = '0;
            else if (ovf) full = '1;
            else full = neg ? -acc : acc;
            if (key_kind == KEY_FRAME) begin
                frame_val = full[31:0]; seen[0] = 1;
            end else begin
                mask_val = full[31:0]; seen[1] = 1;
            end
            phase = PH_POST_VAL;
            if (quoted) begin
                if (c != "\"") failed = 1;
            end else after_value(c);
            return;
        end
        if (tok_len >= TOK_MAX) begin
            failed = 1;
            return;
        end
        tok_len++;
        digit_step(c);
    endtask

    task automatic key_char(logic [7:0] c);
        string word;
        if (c == "\"") begin
            if ((key_kind == KEY_FRAME && key_pos == 5) ||
                (key_kind == KEY_BUTTONS && key_pos == 7)) phase = PH_POST_KEY;
            else failed = 1;
            return;
        end
        case (key_kind)
            KEY_NONE: begin
                if (c == "f") begin key_kind = KEY_FRAME; key_pos = 1; end
                else if (c == "b") begin key_kind = KEY_BUTTONS; key_pos = 1; end
                else key_kind = KEY_BAD;
            end
            KEY_FRAME, KEY_BUTTONS: begin
                word = (key_kind == KEY_FRAME) ? "frame" : "buttons";
                if (key_pos < word.len() && c == word[key_pos]) key_pos++;
                else key_kind = KEY_BAD;
            end
            default: ;
        endcase
    endtask

    task automatic parse_byte(logic [7:0] c);
        if (failed) return;
        case (phase)
            PH_TOP: begin
                if (is_blank(c) || c == CH_CR || c == CH_LF) return;
                if (c == "#") phase = PH_COMMENT;
                else if (c == "{") begin
                    phase = PH_PRE_KEY; seen = '0; frame_val = '0; mask_val = '0;
                end else failed = 1;
            end
            PH_COMMENT: if (c == CH_LF) phase = PH_TOP;
            PH_PRE_KEY: begin
                if (is_blank(c)) return;
                if (c == "\"") begin
                    phase = PH_KEY; key_kind = KEY_NONE; key_pos = 0;
                end else failed = 1;
            end
            PH_KEY: key_char(c);
            PH_POST_KEY: begin
                if (is_blank(c)) return;
                if (c == ":") phase = PH_PRE_VAL;
                else failed = 1;
            end
            PH_PRE_VAL: begin
                if (is_blank(c)) return;
                quoted = (c == "\""); acc = '0; neg = 0; ovf = 0;
                radix = 10; tok_len = 0; phase = PH_V_LEAD;
                if (!quoted) value_char(c);
            end
            PH_V_LEAD, PH_V_SIGNED, PH_V_ZERO, PH_V_HEXPFX, PH_V_DIGITS, PH_V_BAD:
                value_char(c);
            PH_POST_VAL: after_value(c);
            default: failed = 1;
        endcase
    endtask

    // Apply one accepted request; queue the answer it causes, if any.
    task automatic predict_request(request_t r);
        answer_t a;
        int lo, hi, mid;
        case (r.op)
            OP_START: clear_trace();
            OP_BYTE:  parse_byte(r.data);
            OP_END: begin
                if (phase != PH_TOP && phase != PH_COMMENT) failed = 1;
                phase = PH_TOP;
                a = '{RK_STATUS, !failed, 16'h0, 13'(entry_cnt)};
                expected_answers.push_back(a);
            end
            default: begin
                lo = 0; hi = entry_cnt;
                while (lo < hi) begin
                    mid = lo + (hi - lo) / 2;
                    if (tbl_frame[mid] <= r.query) lo = mid + 1;
                    else hi = mid;
                end
                a = '{RK_LOOKUP, 1'b0, (lo > 0) ? tbl_mask[lo-1] : 16'h0, 13'(entry_cnt)};
                expected_answers.push_back(a);
            end
        endcase
    endtask

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------
    task automatic push_op(t_op op, logic [31:0] q = '0);
        request_t r;
        r = '{op, 8'($urandom), q, 1'b0};
        if (op == OP_BYTE) r.data = q[7:0];
        pending_reqs.push_back(r);
    endtask

    task automatic push_text(string s);
        foreach (s[i]) push_op(OP_BYTE, 32'(s[i]));
    endtask

    function automatic string pad();
        case ($urandom_range(0, 5))
            0: return " ";
            1: return "\t";
            2: return "  ";
            default: return "";
        endcase
    endfunction

    function automatic string number_text(logic [31:0] v);
        string s;
        case ($urandom_range(0, 9))
            0, 1: s = $sformatf("0x%0h", v);
            2:    s = $sformatf("0X%0H", v);
            3:    s = (v == 0) ? "0" : $sformatf("0%0o", v);
            4:    s = $sformatf("+%0d", v);
            5:    s = $sformatf("-%0d", -v);
            6:    s = (v == 0) ? "00" : $sformatf("%0d", v);
            default: s = $sformatf("%0d", v);
        endcase
        if ($urandom_range(0, 3) == 0) s = {"\"", s, "\""};
        return s;
    endfunction

    function automatic string field_text(string key, logic [31:0] v);
        return {pad(), "\"", key, "\"", pad(), ":", pad(), number_text(v), pad()};
    endfunction

    // Well-formed record with random layout; the caller picks frame and mask.
    task automatic push_record(logic [31:0] fr, logic [31:0] mk);
        string s, f, b;
        f = field_text("frame", fr);
        b = field_text("buttons", mk);
        if ($urandom_range(0, 9) == 0) f = {field_text("frame", $urandom), ",", f};
        s = ($urandom_range(0, 1) == 0) ? {"{", f, ",", b, "}"} : {"{", b, ",", f, "}"};
        case ($urandom_range(0, 7))
            0: s = {"# note ", pad(), "\n", s};
            1: s = {"\r\n", s};
            2: s = {" \t", s, "\n"};
            default: ;
        endcase
        push_text(s);
    endtask

    // ---------------------------------------------------------------------
    // Request driver
    // ---------------------------------------------------------------------
    int in_idle_pct, out_idle_pct;

    always_comb begin
        if (accepted < total_reqs / 3) begin
            in_idle_pct = 21; out_idle_pct = 79;
        end else if (accepted < 2 * total_reqs / 3) begin
            in_idle_pct = 79; out_idle_pct = 21;
        end else begin
            in_idle_pct = 0; out_idle_pct = 0;
        end
    end

    always @(posedge clk) begin
        request_t r;
        if (!rst_n) begin
            req_if.valid       <= 1'b0;
            req_if.operation   <= OP_START;
            req_if.data_byte   <= '0;
            req_if.query_frame <= '0;
            draining <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                predict_request('{t_op'(req_if.operation), req_if.data_byte,
                                  req_if.query_frame, 1'b0});
                accepted++;
            end
            if (!req_if.valid || req_if.ready) begin
                // hold off while a drain marker waits for all results
                if (pending_reqs.size() > 0 && pending_reqs[0].drain) begin
                    req_if.valid <= 1'b0;
                    draining <= 1'b1;
                    if (expected_answers.size() == 0 && !req_if.valid)
                        void'(pending_reqs.pop_front());
                end else if (pending_reqs.size() > 0 &&
                             $urandom_range(0, 99) >= in_idle_pct) begin
                    r = pending_reqs.pop_front();
                    req_if.valid       <= 1'b1;
                    req_if.operation   <= r.op;
                    req_if.data_byte   <= r.data;
                    req_if.query_frame <= r.query;
                    draining <= 1'b0;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Response monitor
    // ---------------------------------------------------------------------
    task automatic report_mismatch(string what, int got, int want);
        error_count++;
        $display("MISMATCH %s: got %0h expected %0h (request %0d)", what, got, want, accepted);
    endtask

    always @(posedge clk) begin
        answer_t e;
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_answers.size() == 0) begin
                    report_mismatch("unexpected result kind", rsp_if.result_kind, 0);
                end else begin
                    e = expected_answers.pop_front();
                    if (rsp_if.result_kind !== e.kind)
                        report_mismatch("result_kind", rsp_if.result_kind, e.kind);
                    if (rsp_if.parse_ok !== e.ok)
                        report_mismatch("parse_ok", rsp_if.parse_ok, e.ok);
                    if (rsp_if.buttons_mask !== e.mask)
                        report_mismatch("buttons_mask", rsp_if.buttons_mask, e.mask);
                    if (rsp_if.entries_held !== e.held)
                        report_mismatch("entries_held", rsp_if.entries_held, e.held);
                end
            end
            rsp_if.ready <= ($urandom_range(0, 99) >= out_idle_pct);
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus and end of run
    // ---------------------------------------------------------------------
    initial begin
        logic [31:0] next_frame;
        request_t    hold;
        clear_trace();

        // directed: comments, every radix, extremes of frame and mask
        push_op(OP_START);
        push_op(OP_LOOKUP, 32'h0);
        push_text(" # head\n{\"frame\":0,\"buttons\":0}\r\n");
        push_text("{ \"frame\" : \"0x10\" , \"buttons\":0177}");
        push_op(OP_LOOKUP, 32'h0);
        push_op(OP_LOOKUP, 32'hf);
        push_op(OP_LOOKUP, 32'h10);
        push_op(OP_END);
        // further buffer without a start keeps the table
        push_text("{\"buttons\":\"0XFFFF\",\"frame\":4294967295}");
        push_op(OP_END);
        push_op(OP_LOOKUP, 32'hffff_ffff);
        // repeated key, mask too large
        push_op(OP_START);
        push_op(OP_LOOKUP, 32'd5);
        push_text("{\"frame\":5,\"frame\":6,\"buttons\":65536}");
        push_op(OP_END);
        // sign, overflow saturation, end inside a record
        push_op(OP_START);
        push_text("{\"frame\":-1,\"buttons\":+7}{\"frame\":\"99999999999999999999999\",");
        push_op(OP_END);
        push_op(OP_LOOKUP, 32'hffff_ffff);
        // bad key, zero byte, too many characters, bad digits
        push_op(OP_START);
        push_text("{\"fram\":1}");
        push_op(OP_END);
        push_op(OP_START);
        push_text("{\"frame\":1");
        push_op(OP_BYTE, 32'h0);
        push_op(OP_END);
        push_op(OP_START);
        push_text("{\"frame\":00000000000000000000000000000001,\"buttons\":1}");
        push_op(OP_END);
        push_op(OP_START);
        push_text("{\"frame\":08,\"buttons\":0x}{\"frame\":1,\"buttons\":2}");
        push_op(OP_END);
        push_op(OP_START);
        push_text("{\"buttons\":1}");
        push_op(OP_END);

        // random: mostly good records with lookups, some noise and breaks
        push_op(OP_START);
        next_frame = $urandom_range(0, 20);
        while (pending_reqs.size() < 1750) begin
            case ($urandom_range(0, 99)) inside
                [0:64]: begin
                    if ($urandom_range(0, 29) == 0) next_frame = next_frame - $urandom_range(0, 3);
                    push_record(next_frame,
                                ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 16'hffff));
                    next_frame = next_frame + $urandom_range(1, 40);
                end
                [65:84]: push_op(OP_LOOKUP,
                                 ($urandom_range(0, 3) == 0) ? $urandom : next_frame - $urandom_range(0, 60));
                [85:90]: begin
                    push_op(OP_END);
                    if ($urandom_range(0, 1) == 0) begin
                        push_op(OP_START);
                        next_frame = $urandom_range(0, 20);
                    end
                end
                [91:96]: push_op(OP_BYTE, $urandom_range(0, 255));
                default: begin
                    push_op(OP_START);
                    next_frame = $urandom;
                    if (next_frame > 32'hf000_0000) next_frame = 32'hffff_fff0;
                end
            endcase
        end
        push_op(OP_END);

        // wait for every result, then ask a few more lookups
        hold = '{OP_START, 8'h0, 32'h0, 1'b1};
        pending_reqs.push_back(hold);
        push_op(OP_LOOKUP, 32'hffff_ffff);
        push_op(OP_LOOKUP, 32'd2048);
        push_op(OP_LOOKUP, 32'd0);
        total_reqs = pending_reqs.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_reqs.size() == 0);
        @(posedge clk iff !req_if.valid);
        wait (expected_answers.size() == 0);
        repeat (60) @(posedge clk);
        if (error_count == 0 && expected_answers.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/btpl_pkg.sv
rtl/btpl_if.sv
rtl/btpl_table.sv
rtl/button_trace_parse_and_lookup.sv
rtl/btpl_check.sv
tb/testbench.sv
